// ----- rtl/per_column_running_mean_variance_assert.svh -----
// Assertion macros used by the per-column mean and variance controller.
`ifndef PER_COLUMN_RUNNING_MEAN_VARIANCE_ASSERT_SVH
`define PER_COLUMN_RUNNING_MEAN_VARIANCE_ASSERT_SVH

// Condition that must hold at every edge outside reset.
`define PCMV_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define PCMV_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/pcmv_pkg.sv -----
// Shared constants and controller/datapath interface types for the mean/variance block.
`default_nettype none
package pcmv_pkg;
   localparam int SAMPLE_W      = 32;
   localparam int FIX_W         = 48;   // Q16.32 mean
   localparam int DIFF_W        = 49;
   localparam int M2_W          = 64;   // Q40.24 sum of squared deviations
   localparam int PROD_W        = 98;
   localparam int PROD_SHIFT    = 40;
   localparam int DIVIDEND_W    = 64;
   localparam int DIVISOR_W     = 32;
   localparam int STEP_W        = 7;
   localparam int ACC_DIV_STEPS = 49;
   localparam int FIN_DIV_STEPS = 64;
   localparam int MUL_STEPS     = 5;
   localparam int ROOT_STEPS    = 32;
   localparam logic [30:0] STD_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic       acc_start;   // accumulate word taken: pick column, read RAM
      logic       fin_start;   // finish word taken
      logic       a_diff;      // d1 = x - mean, start divide by row count
      logic       a_update;    // new mean
      logic       a_d2;        // d2 and its magnitude
      logic       mul_step;
      logic [2:0] mul_idx;
      logic       a_write;     // write back mean and m2
      logic       f_read;
      logic       f_load;      // latch column, start variance divide
      logic       f_root_init;
      logic       root_step;
      logic       f_emit;
      logic       f_clear;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic short_run;
      logic out_free;
      logic last_col;
   } status_type;
endpackage
`default_nettype wire

// ----- rtl/per_column_running_mean_variance.sv -----
// Top level: per-column running mean, standard deviation and peak magnitude.
//
//  channel | direction | handshake             | contents
//  req     | in        | req_valid / req_stall | action, sample (Q16.16)
//  rsp     | out       | rsp_valid / rsp_stall | one word per column on finish
//  csr     | in        | csr_write_enable      | column_count (5 bits)
//
//  Accumulate word: a 49-step restoring divider (d1 / rows), then a 4-product
//  multiply over one 32x32 multiplier.
//  Finish per column: a 64-step variance divide, then a 32-step square root;
//  both are skipped when fewer than two rows were seen.
//  Reset is synchronous; column state RAM is cleared through per-entry valid bits.
//  A stalled result word holds; the next word is only built into a free slot.
`default_nettype none
module per_column_running_mean_variance #(
   parameter int MAX_COLUMNS    = 16,
   parameter int ROW_COUNT_BITS = 24
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_action,
   input  wire logic signed [31:0] req_sample,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [3:0]              rsp_column_index,
   output logic signed [31:0]      rsp_mean_value,
   output logic [30:0]             rsp_std_deviation,
   output logic                    rsp_deviation_invalid,
   output logic [23:0]             rsp_rows_seen,
   output logic [31:0]             rsp_largest_magnitude,
   output logic                    rsp_last_result,
   input  wire logic               csr_write_enable,
   input  wire logic [4:0]         csr_write_data
);
   pcmv_pkg::cmd_type    cmd;
   pcmv_pkg::status_type status;

   pcmv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   pcmv_datapath #(
      .MAX_COLUMNS    (MAX_COLUMNS),
      .ROW_COUNT_BITS (ROW_COUNT_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .req_sample            (req_sample),
      .cmd                   (cmd),
      .status                (status),
      .rsp_stall             (rsp_stall),
      .rsp_valid             (rsp_valid),
      .rsp_column_index      (rsp_column_index),
      .rsp_mean_value        (rsp_mean_value),
      .rsp_std_deviation     (rsp_std_deviation),
      .rsp_deviation_invalid (rsp_deviation_invalid),
      .rsp_rows_seen         (rsp_rows_seen),
      .rsp_largest_magnitude (rsp_largest_magnitude),
      .rsp_last_result       (rsp_last_result)
   );
endmodule
`default_nettype wire

// ----- rtl/pcmv_ram.sv -----
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module pcmv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- rtl/pcmv_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle, step count set at start.
`default_nettype none
module pcmv_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [pcmv_pkg::STEP_W-1:0]         steps,
   input  wire logic [pcmv_pkg::DIVIDEND_W-1:0]     dividend,
   input  wire logic [pcmv_pkg::DIVISOR_W-1:0]      divisor,
   output logic                                     done,
   output logic      [pcmv_pkg::DIVIDEND_W-1:0]     quotient
);
   logic [pcmv_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [pcmv_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [pcmv_pkg::DIVISOR_W-1:0]  den_ff;
   logic [pcmv_pkg::STEP_W-1:0]     cnt_ff;
   logic                            busy_ff, done_ff;
   logic [pcmv_pkg::DIVISOR_W:0]    shifted, diff;
   logic                            ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[pcmv_pkg::DIVIDEND_W-1]};
      diff    = shifted - {1'b0, den_ff};
      ge      = !diff[pcmv_pkg::DIVISOR_W];
      rem_in  = ge ? diff[pcmv_pkg::DIVISOR_W-1:0] : shifted[pcmv_pkg::DIVISOR_W-1:0];
      quo_in  = {quo_ff[pcmv_pkg::DIVIDEND_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == pcmv_pkg::STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ----- rtl/pcmv_datapath.sv -----
// Datapath: column state RAM, Welford update, multiplier, divider, square root, result word.
`default_nettype none
module pcmv_datapath #(
   parameter int MAX_COLUMNS    = 16,
   parameter int ROW_COUNT_BITS = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [4:0]            csr_write_data,
   input  wire logic signed [31:0]    req_sample,
   input  wire pcmv_pkg::cmd_type     cmd,
   output pcmv_pkg::status_type       status,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output logic [3:0]                 rsp_column_index,
   output logic signed [31:0]         rsp_mean_value,
   output logic [30:0]                rsp_std_deviation,
   output logic                       rsp_deviation_invalid,
   output logic [23:0]                rsp_rows_seen,
   output logic [31:0]                rsp_largest_magnitude,
   output logic                       rsp_last_result
);
   localparam int CIDX = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int RAM_W = pcmv_pkg::FIX_W + pcmv_pkg::M2_W;
   localparam int RCB = ROW_COUNT_BITS;

   // configuration and run state
   logic [4:0]             col_count_ff;
   logic [CIDX-1:0]        cur_col_ff, col_ff, fin_col_ff;
   logic [RCB-1:0]         rows_ff;
   logic [31:0]            peak_ff;
   logic [MAX_COLUMNS-1:0] valid_ff;
   logic                   rd_valid_ff;

   // accumulate working registers
   logic signed [31:0]     sample_ff;
   logic [pcmv_pkg::DIFF_W-1:0] d1_ff, a_ff, b_ff;
   logic [pcmv_pkg::FIX_W-1:0]  mean_ff, mean_new_ff;
   logic [pcmv_pkg::M2_W-1:0]   m2_ff;
   logic [63:0]                 pp_ff;
   logic [1:0]                  pp_sel_ff;
   logic [pcmv_pkg::PROD_W-1:0] acc_ff;
   logic                        same_ff;

   // finish working registers
   logic        big_ff, sat_ff;
   logic [63:0] v_ff, root_ff, bit_ff;
   logic [31:0] fin_mean_ff;

   // result word
   logic        rsp_valid_ff;
   logic [3:0]  out_col_ff;
   logic [31:0] out_mean_ff;
   logic [30:0] out_std_ff;
   logic        out_inv_ff, out_last_ff;
   logic [23:0] out_rows_ff;
   logic [31:0] out_peak_ff;

   logic [7:0]            eff, cur_ext, nxt_ext, fin_ext;
   logic [CIDX-1:0]       col_sel, rd_addr;
   logic [RAM_W-1:0]      rd_data, wr_data;
   logic [pcmv_pkg::FIX_W-1:0] rd_mean, x;
   logic [pcmv_pkg::M2_W-1:0]  rd_m2, m2_new;
   logic [pcmv_pkg::DIFF_W-1:0] d1, d1_abs, q49, qs, mean_sum, d2;
   logic [31:0]           mag;
   logic                  div_start, div_done;
   logic [pcmv_pkg::STEP_W-1:0]     div_steps;
   logic [pcmv_pkg::DIVIDEND_W-1:0] div_dividend, quot;
   logic [pcmv_pkg::DIVISOR_W-1:0]  div_divisor;
   logic [31:0]           mul_a, mul_b;
   logic [pcmv_pkg::PROD_W-1:0] pp_shifted;
   logic [64:0]           m2_sum;
   logic [63:0]           root_t;
   logic [64:0]           root_diff;
   logic [32:0]           rows_ext;
   logic [23:0]           rows_out;
   logic [30:0]           std_val;
   logic                  short_run, last_col, out_free;

   always_comb begin
      if (col_count_ff == 5'd0) begin
         eff = 8'd1;
      end else if (8'(col_count_ff) > 8'(MAX_COLUMNS)) begin
         eff = 8'(MAX_COLUMNS);
      end else begin
         eff = 8'(col_count_ff);
      end
      cur_ext = 8'(cur_col_ff);
      col_sel = (cur_ext >= eff) ? '0 : cur_col_ff;
      nxt_ext = 8'(col_ff) + 8'd1;
      fin_ext = 8'(fin_col_ff) + 8'd1;
      last_col = (fin_ext == eff);
      short_run = (rows_ff < RCB'(2));
      out_free = !rsp_valid_ff || !rsp_stall;
      mag = req_sample[31] ? 32'(-req_sample) : 32'(req_sample);
      rows_ext = 33'(rows_ff);
      rows_out = (rows_ext > 33'h0FF_FFFF) ? 24'hFF_FFFF : rows_ext[23:0];
   end

   // RAM word: mean in the upper bits, m2 below; an entry without its valid bit reads zero
   always_comb begin
      rd_addr = cmd.acc_start ? col_sel : fin_col_ff;
      rd_mean = rd_valid_ff ? rd_data[RAM_W-1:pcmv_pkg::M2_W] : '0;
      rd_m2   = rd_valid_ff ? rd_data[pcmv_pkg::M2_W-1:0] : '0;
   end

   pcmv_ram #(.WIDTH(RAM_W), .DEPTH(MAX_COLUMNS)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.a_write),
      .wr_addr (col_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.acc_start | cmd.f_read),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Welford arithmetic
   always_comb begin
      x        = {sample_ff, 16'h0000};
      d1       = {x[pcmv_pkg::FIX_W-1], x} - {rd_mean[pcmv_pkg::FIX_W-1], rd_mean};
      d1_abs   = d1[pcmv_pkg::DIFF_W-1] ? -d1 : d1;
      q49      = quot[pcmv_pkg::DIFF_W-1:0];
      qs       = d1_ff[pcmv_pkg::DIFF_W-1] ? -q49 : q49;
      mean_sum = {mean_ff[pcmv_pkg::FIX_W-1], mean_ff} + qs;
      d2       = {x[pcmv_pkg::FIX_W-1], x}
                 - {mean_new_ff[pcmv_pkg::FIX_W-1], mean_new_ff};
      m2_sum   = 65'(m2_ff) + 65'(acc_ff[pcmv_pkg::PROD_W-1:pcmv_pkg::PROD_SHIFT]);
      if (!same_ff) begin
         m2_new = m2_ff;
      end else if (m2_sum[64]) begin
         m2_new = '1;
      end else begin
         m2_new = m2_sum[63:0];
      end
      wr_data = {mean_new_ff, m2_new};
   end

   // four 32x32 partial products of |d1| * |d2|
   always_comb begin
      case (cmd.mul_idx[1:0])
         2'd0: begin
            mul_a = a_ff[31:0];
            mul_b = b_ff[31:0];
         end
         2'd1: begin
            mul_a = a_ff[31:0];
            mul_b = 32'(b_ff[pcmv_pkg::DIFF_W-1:32]);
         end
         2'd2: begin
            mul_a = 32'(a_ff[pcmv_pkg::DIFF_W-1:32]);
            mul_b = b_ff[31:0];
         end
         default: begin
            mul_a = 32'(a_ff[pcmv_pkg::DIFF_W-1:32]);
            mul_b = 32'(b_ff[pcmv_pkg::DIFF_W-1:32]);
         end
      endcase
      case (pp_sel_ff)
         2'd0:    pp_shifted = pcmv_pkg::PROD_W'(pp_ff);
         2'd3:    pp_shifted = pcmv_pkg::PROD_W'(pp_ff) << 64;
         default: pp_shifted = pcmv_pkg::PROD_W'(pp_ff) << 32;
      endcase
   end

   // divider operands
   always_comb begin
      div_start = cmd.a_diff | (cmd.f_load & !short_run);
      if (cmd.f_load) begin
         div_steps    = pcmv_pkg::STEP_W'(pcmv_pkg::FIN_DIV_STEPS);
         div_divisor  = pcmv_pkg::DIVISOR_W'(rows_ff) - 32'd1;
         div_dividend = (rd_m2[63:56] != 8'd0) ? rd_m2 : {rd_m2[55:0], 8'h00};
      end else begin
         div_steps    = pcmv_pkg::STEP_W'(pcmv_pkg::ACC_DIV_STEPS);
         div_divisor  = pcmv_pkg::DIVISOR_W'(rows_ff);
         div_dividend = {d1_abs, 15'h0000};
      end
   end

   pcmv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .steps    (div_steps),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quot)
   );

   // square root step
   always_comb begin
      root_t    = root_ff + bit_ff;
      root_diff = {1'b0, v_ff} - {1'b0, root_t};
      if (short_run) begin
         std_val = '0;
      end else if (sat_ff || (root_ff[63:31] != 33'd0)) begin
         std_val = pcmv_pkg::STD_MAX;
      end else begin
         std_val = root_ff[30:0];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= 5'd1;
         cur_col_ff   <= '0;
         fin_col_ff   <= '0;
         rows_ff      <= '0;
         peak_ff      <= '0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            col_count_ff <= csr_write_data;
         end
         if (cmd.acc_start | cmd.f_read) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
         if (cmd.acc_start) begin
            if ((col_sel == '0) && (rows_ff != '1)) begin
               rows_ff <= rows_ff + 1'b1;
            end
            if (mag > peak_ff) begin
               peak_ff <= mag;
            end
         end
         if (cmd.a_write) begin
            valid_ff[col_ff] <= 1'b1;
            cur_col_ff <= (nxt_ext >= eff) ? '0 : nxt_ext[CIDX-1:0];
         end
         if (cmd.fin_start) begin
            fin_col_ff <= '0;
         end else if (cmd.f_emit) begin
            fin_col_ff <= CIDX'(fin_ext);
         end
         if (cmd.f_clear) begin
            valid_ff   <= '0;
            cur_col_ff <= '0;
            rows_ff    <= '0;
            peak_ff    <= '0;
         end
         if (cmd.f_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      if (cmd.acc_start) begin
         sample_ff <= req_sample;
         col_ff    <= col_sel;
      end
      if (cmd.a_diff) begin
         d1_ff   <= d1;
         mean_ff <= rd_mean;
         m2_ff   <= rd_m2;
      end
      if (cmd.a_update) begin
         mean_new_ff <= mean_sum[pcmv_pkg::FIX_W-1:0];
         a_ff <= d1_ff[pcmv_pkg::DIFF_W-1] ? -d1_ff : d1_ff;
      end
      if (cmd.a_d2) begin
         b_ff    <= d2[pcmv_pkg::DIFF_W-1] ? -d2 : d2;
         same_ff <= (d1_ff != '0) && (d2 != '0)
                    && (d1_ff[pcmv_pkg::DIFF_W-1] == d2[pcmv_pkg::DIFF_W-1]);
         acc_ff  <= '0;
      end
      if (cmd.mul_step) begin
         if (cmd.mul_idx < 3'(pcmv_pkg::MUL_STEPS - 1)) begin
            pp_ff     <= mul_a * mul_b;
            pp_sel_ff <= cmd.mul_idx[1:0];
         end
         if (cmd.mul_idx != 3'd0) begin
            acc_ff <= acc_ff + pp_shifted;
         end
      end
      if (cmd.f_load) begin
         fin_mean_ff <= rd_mean[pcmv_pkg::FIX_W-1:16];
         big_ff      <= (rd_m2[63:56] != 8'd0);
      end
      if (cmd.f_root_init) begin
         root_ff <= '0;
         bit_ff  <= 64'h4000_0000_0000_0000;
         if (big_ff) begin
            sat_ff <= (quot[63:54] != 10'd0);
            v_ff   <= {quot[55:0], 8'h00};
         end else begin
            sat_ff <= 1'b0;
            v_ff   <= quot;
         end
      end
      if (cmd.root_step) begin
         if (!root_diff[64]) begin
            v_ff    <= root_diff[63:0];
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.f_emit) begin
         out_col_ff  <= 4'(fin_col_ff);
         out_mean_ff <= fin_mean_ff;
         out_std_ff  <= std_val;
         out_inv_ff  <= short_run;
         out_rows_ff <= rows_out;
         out_peak_ff <= peak_ff;
         out_last_ff <= last_col;
      end
   end

   assign status = '{div_done: div_done, short_run: short_run,
                     out_free: out_free, last_col: last_col};

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_column_index      = out_col_ff;
   assign rsp_mean_value        = out_mean_ff;
   assign rsp_std_deviation     = out_std_ff;
   assign rsp_deviation_invalid = out_inv_ff;
   assign rsp_rows_seen         = out_rows_ff;
   assign rsp_largest_magnitude = out_peak_ff;
   assign rsp_last_result       = out_last_ff;
endmodule
`default_nettype wire

// ----- rtl/pcmv_ctrl.sv -----
// Controller: sequences the accumulate update and the per-column finish walk.
`default_nettype none
module pcmv_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_action,
   output logic                      req_stall,
   input  wire pcmv_pkg::status_type status,
   output pcmv_pkg::cmd_type         cmd
);
`include "per_column_running_mean_variance_assert.svh"

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_A_DIFF  = 4'd1;
   localparam logic [3:0] S_A_DIV   = 4'd2;
   localparam logic [3:0] S_A_UPD   = 4'd3;
   localparam logic [3:0] S_A_D2    = 4'd4;
   localparam logic [3:0] S_A_MUL   = 4'd5;
   localparam logic [3:0] S_A_WR    = 4'd6;
   localparam logic [3:0] S_F_RD    = 4'd7;
   localparam logic [3:0] S_F_LD    = 4'd8;
   localparam logic [3:0] S_F_DIV   = 4'd9;
   localparam logic [3:0] S_F_RINIT = 4'd10;
   localparam logic [3:0] S_F_ROOT  = 4'd11;
   localparam logic [3:0] S_F_OUT   = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [5:0] step_ff, step_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_action) begin
                  cmd.fin_start = 1'b1;
                  state_in = S_F_RD;
               end else begin
                  cmd.acc_start = 1'b1;
                  state_in = S_A_DIFF;
               end
            end
         end
         S_A_DIFF: begin
            cmd.a_diff = 1'b1;
            state_in = S_A_DIV;
         end
         S_A_DIV: begin
            if (status.div_done) begin
               state_in = S_A_UPD;
            end
         end
         S_A_UPD: begin
            cmd.a_update = 1'b1;
            state_in = S_A_D2;
         end
         S_A_D2: begin
            cmd.a_d2 = 1'b1;
            step_in  = '0;
            state_in = S_A_MUL;
         end
         S_A_MUL: begin
            cmd.mul_step = 1'b1;
            cmd.mul_idx  = 3'(step_ff);
            step_in      = step_ff + 6'd1;
            if (step_ff == 6'(pcmv_pkg::MUL_STEPS - 1)) begin
               state_in = S_A_WR;
            end
         end
         S_A_WR: begin
            cmd.a_write = 1'b1;
            state_in = S_IDLE;
         end
         S_F_RD: begin
            cmd.f_read = 1'b1;
            state_in = S_F_LD;
         end
         S_F_LD: begin
            cmd.f_load = 1'b1;
            state_in = status.short_run ? S_F_OUT : S_F_DIV;
         end
         S_F_DIV: begin
            if (status.div_done) begin
               state_in = S_F_RINIT;
            end
         end
         S_F_RINIT: begin
            cmd.f_root_init = 1'b1;
            step_in  = '0;
            state_in = S_F_ROOT;
         end
         S_F_ROOT: begin
            cmd.root_step = 1'b1;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'(pcmv_pkg::ROOT_STEPS - 1)) begin
               state_in = S_F_OUT;
            end
         end
         S_F_OUT: begin
            if (status.out_free) begin
               cmd.f_emit = 1'b1;
               if (status.last_col) begin
                  cmd.f_clear = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_F_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   `PCMV_ASSERT_ALWAYS(a_emit_into_free, clock, reset, (!cmd.f_emit || status.out_free), "result word overwritten")
   `PCMV_ASSERT_ALWAYS(a_div_done_waited, clock, reset, (!status.div_done || state_ff == S_A_DIV || state_ff == S_F_DIV), "divider finished while not awaited")
   `PCMV_ASSERT_NEXT(a_accum_starts, clock, reset, (accept && !req_action), (state_ff == S_A_DIFF), "accumulate word did not start update")
endmodule
`default_nettype wire

// ----- sim/per_column_running_mean_variance_test.sv -----
// Testbench for the per-column running mean and standard deviation block.
`timescale 1ns / 100ps
`default_nettype none
module per_column_running_mean_variance_test;
   localparam int COLUMNS_MAX = 16;
   localparam logic ACTION_ADD = 1'b0;
   localparam logic ACTION_FINISH = 1'b1;
   localparam logic [63:0] SUM_SQ_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [23:0] ROWS_MAX = 24'hFF_FFFF;
   localparam int SETTLE_CYCLES = 300;

   typedef struct packed {
      logic [3:0]  column_index;
      logic [31:0] mean_value;
      logic [30:0] std_deviation;
      logic        deviation_invalid;
      logic [23:0] rows_seen;
      logic [31:0] largest_magnitude;
      logic        last_result;
   } column_stats_type;

   // Directed row: optional column count write first, then the word.
   typedef struct {
      int           csr_value;     // -1: no write
      logic         action;
      logic [31:0]  sample;
      bit           typed;         // expected result given in the row
      column_stats_type stats;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_action = 1'b0;
   logic signed [31:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [3:0] rsp_column_index;
   logic signed [31:0] rsp_mean_value;
   logic [30:0] rsp_std_deviation;
   logic rsp_deviation_invalid;
   logic [23:0] rsp_rows_seen;
   logic [31:0] rsp_largest_magnitude;
   logic rsp_last_result;
   logic csr_write_enable = 1'b0;
   logic [4:0] csr_write_data = '0;

   per_column_running_mean_variance i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_sample            (req_sample),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_column_index      (rsp_column_index),
      .rsp_mean_value        (rsp_mean_value),
      .rsp_std_deviation     (rsp_std_deviation),
      .rsp_deviation_invalid (rsp_deviation_invalid),
      .rsp_rows_seen         (rsp_rows_seen),
      .rsp_largest_magnitude (rsp_largest_magnitude),
      .rsp_last_result       (rsp_last_result),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the block's accumulation state.
   logic signed [63:0] col_mean [COLUMNS_MAX];   // Q16.32
   logic [63:0]        col_sum_sq [COLUMNS_MAX]; // Q40.24
   int unsigned        next_col;
   logic [23:0]        row_total;
   logic [31:0]        peak_abs;
   logic [4:0]         column_reg;

   column_stats_type expected_stats [$];
   int mismatch_count = 0;
   int words_sent = 0;
   int finishes_sent = 0;
   int results_checked = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   function automatic int unsigned active_columns();
      if (column_reg == 0) return 1;
      if (column_reg > COLUMNS_MAX) return COLUMNS_MAX;
      return 32'(column_reg);
   endfunction

   function automatic void clear_stats();
      for (int i = 0; i < COLUMNS_MAX; i++) begin
         col_mean[i] = '0;
         col_sum_sq[i] = '0;
      end
      next_col = 0;
      row_total = '0;
      peak_abs = '0;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] one_bit;
      root = '0;
      one_bit = 64'h1 << 62;
      while (one_bit > v) one_bit = one_bit >> 2;
      while (one_bit != 0) begin
         if (v >= root + one_bit) begin
            v = v - (root + one_bit);
            root = (root >> 1) + one_bit;
         end else begin
            root = root >> 1;
         end
         one_bit = one_bit >> 2;
      end
      return root;
   endfunction

   function automatic logic [30:0] sample_std(logic [63:0] m2, logic [23:0] rows);
      logic [63:0] den;
      logic [63:0] var_q32;
      logic [63:0] var_q24;
      den = 64'(rows) - 64'd1;
      if (m2 < (64'h1 << 56)) begin
         var_q32 = (m2 << 8) / den;
      end else begin
         var_q24 = m2 / den;
         if (var_q24 >= (64'h1 << 54)) return 31'h7FFF_FFFF;
         var_q32 = var_q24 << 8;
      end
      var_q32 = int_sqrt(var_q32);
      return (var_q32 > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : var_q32[30:0];
   endfunction

   function automatic void add_sample(logic [31:0] raw);
      logic signed [63:0] s;
      logic signed [63:0] x;
      logic signed [63:0] d1;
      logic signed [63:0] d2;
      logic [63:0] mag;
      logic [127:0] prod;
      logic [63:0] incr;
      int unsigned c;
      s = 64'(signed'(raw));
      mag = (s < 0) ? 64'(-s) : 64'(s);
      x = s <<< 16;
      if (next_col >= active_columns()) next_col = 0;
      c = next_col;
      if (c == 0 && row_total < ROWS_MAX) row_total++;
      if (mag > 64'(peak_abs)) peak_abs = mag[31:0];
      d1 = x - col_mean[c];
      col_mean[c] = col_mean[c] + d1 / signed'(64'(row_total));
      d2 = x - col_mean[c];
      if ((d1 > 0 && d2 > 0) || (d1 < 0 && d2 < 0)) begin
         prod = 128'((d1 < 0) ? -d1 : d1) * 128'((d2 < 0) ? -d2 : d2);
         incr = prod[103:40];
         col_sum_sq[c] = (col_sum_sq[c] > SUM_SQ_MAX - incr) ? SUM_SQ_MAX
                                                            : col_sum_sq[c] + incr;
      end
      next_col = c + 1;
      if (next_col >= active_columns()) next_col = 0;
   endfunction

   // Queues one expectation per column, then starts a new run.
   function automatic void predict_finish();
      column_stats_type r;
      int unsigned n;
      logic [63:0] m;
      n = active_columns();
      for (int unsigned i = 0; i < n; i++) begin
         m = col_mean[i];
         r.column_index = i[3:0];
         r.mean_value = m[47:16];
         r.deviation_invalid = (row_total < 2);
         r.std_deviation = (row_total < 2) ? '0 : sample_std(col_sum_sq[i], row_total);
         r.rows_seen = row_total;
         r.largest_magnitude = peak_abs;
         r.last_result = (i + 1 == n);
         expected_stats.push_back(r);
      end
      clear_stats();
   endfunction

   always @(posedge clock) begin
      column_stats_type got;
      column_stats_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_column_index, rsp_mean_value, rsp_std_deviation,
                 rsp_deviation_invalid, rsp_rows_seen, rsp_largest_magnitude,
                 rsp_last_result};
         results_checked++;
         if (expected_stats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result word col=%0d mean=%h", got.column_index,
                        got.mean_value);
         end else begin
            want = expected_stats.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: exp col=%0d mean=%h std=%h inv=%b rows=%0d ",
                            "peak=%h last=%b / got col=%0d mean=%h std=%h inv=%b ",
                            "rows=%0d peak=%h last=%b"},
                           want.column_index, want.mean_value, want.std_deviation,
                           want.deviation_invalid, want.rows_seen,
                           want.largest_magnitude, want.last_result,
                           got.column_index, got.mean_value, got.std_deviation,
                           got.deviation_invalid, got.rows_seen,
                           got.largest_magnitude, got.last_result);
            end
         end
      end
   end

   always @(negedge clock)
      rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);

   // Typed rows replace the predicted words with the given one.
   task automatic send_word(logic action, logic [31:0] sample, bit typed = 1'b0,
                            column_stats_type stats = '0);
      int unsigned before_len;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_sample <= sample;
      do @(posedge clock); while (req_stall);
      words_sent++;
      if (action == ACTION_ADD) begin
         add_sample(sample);
      end else begin
         finishes_sent++;
         before_len = expected_stats.size();
         predict_finish();
         if (typed) begin
            while (expected_stats.size() > before_len) void'(expected_stats.pop_back());
            expected_stats.push_back(stats);
         end
      end
   endtask

   // Column count changes only once the block has drained.
   task automatic write_columns(logic [4:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_stats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      column_reg = value;
   endtask

   function automatic logic [31:0] random_sample(int style);
      case (style)
         0: return $urandom;
         1: return 32'($signed($urandom_range(2 * 1048576)) - 1048576);
         2: begin
            case ($urandom_range(3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return 32'h0001_0000 + $urandom_range(15);
      endcase
   endfunction

   directed_row_type plan [$];

   initial begin
      column_stats_type s;
      directed_row_type row;
      int unsigned cols;
      int rows;
      int style;
      int in_phase;
      column_reg = 5'd1;
      clear_stats();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty run right after reset
      s = '{4'd0, 32'h0, 31'h0, 1'b1, 24'd0, 32'h0, 1'b1};
      plan.push_back('{-1, ACTION_FINISH, 32'h0, 1'b1, s});
      // single most negative sample
      plan.push_back('{-1, ACTION_ADD, 32'h8000_0000, 1'b0, '0});
      s = '{4'd0, 32'h8000_0000, 31'h0, 1'b1, 24'd1, 32'h8000_0000, 1'b1};
      plan.push_back('{-1, ACTION_FINISH, 32'h0, 1'b1, s});
      // full-scale swing: standard deviation saturates
      plan.push_back('{-1, ACTION_ADD, 32'h7FFF_FFFF, 1'b0, '0});
      plan.push_back('{-1, ACTION_ADD, 32'h8000_0000, 1'b0, '0});
      plan.push_back('{-1, ACTION_ADD, 32'h7FFF_FFFF, 1'b0, '0});
      plan.push_back('{-1, ACTION_FINISH, 32'h0, 1'b0, '0});
      // three columns, finish mid-row
      plan.push_back('{3, ACTION_ADD, 32'h0001_0000, 1'b0, '0});
      plan.push_back('{-1, ACTION_ADD, 32'hFFFF_0000, 1'b0, '0});
      plan.push_back('{-1, ACTION_ADD, 32'h0000_0001, 1'b0, '0});
      plan.push_back('{-1, ACTION_ADD, 32'h0003_0000, 1'b0, '0});
      plan.push_back('{-1, ACTION_FINISH, 32'h0, 1'b0, '0});
      // count shrunk after a full row: next word starts a new row
      plan.push_back('{-1, ACTION_ADD, 32'h0002_0000, 1'b0, '0});
      plan.push_back('{-1, ACTION_ADD, 32'h0004_0000, 1'b0, '0});
      plan.push_back('{-1, ACTION_ADD, 32'h0005_8000, 1'b0, '0});
      plan.push_back('{2, ACTION_ADD, 32'h0006_0000, 1'b0, '0});
      plan.push_back('{-1, ACTION_ADD, 32'h0007_0000, 1'b0, '0});
      plan.push_back('{-1, ACTION_FINISH, 32'h0, 1'b0, '0});
      // zero count behaves as one, oversize as sixteen
      plan.push_back('{0, ACTION_ADD, 32'h1234_5678, 1'b0, '0});
      plan.push_back('{-1, ACTION_ADD, 32'hEDCB_A988, 1'b0, '0});
      plan.push_back('{-1, ACTION_FINISH, 32'h0, 1'b0, '0});
      plan.push_back('{31, ACTION_ADD, 32'h0000_0010, 1'b0, '0});
      plan.push_back('{-1, ACTION_FINISH, 32'h0, 1'b0, '0});
      plan.push_back('{16, ACTION_FINISH, 32'h0, 1'b0, '0});

      foreach (plan[i]) begin
         row = plan[i];
         if (row.csr_value >= 0) write_columns(row.csr_value[4:0]);
         send_word(row.action, row.sample, row.typed, row.stats);
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         in_phase = 0;
         while (in_phase < 38) begin
            if ($urandom_range(99) < 40) begin
               case ($urandom_range(3))
                  0: write_columns(5'd1);
                  1: write_columns(5'd16);
                  default: write_columns(5'($urandom_range(31)));
               endcase
            end
            cols = active_columns();
            if ($urandom_range(9) == 0) begin
               // noise: finish with no or a stray sample
               if ($urandom_range(1)) begin
                  send_word(ACTION_ADD, $urandom);
                  in_phase++;
               end
            end else begin
               rows = $urandom_range((cols > 8) ? 2 : 5, 0);
               style = $urandom_range(3);
               for (int k = 0; k < rows * int'(cols) + int'($urandom_range(cols - 1)); k++)
               begin
                  send_word(ACTION_ADD, random_sample(style));
                  in_phase++;
               end
            end
            send_word(ACTION_FINISH, $urandom);
            in_phase++;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_stats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Sent %0d words (%0d finishes); checked %0d result words.",
               words_sent, finishes_sent, results_checked);
      $display("Covered column counts 0..31, saturated variance, partial rows, stalls.");
      if (mismatch_count == 0 && expected_stats.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("timeout with %0d result words outstanding", expected_stats.size());
      $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/pcmv_pkg.sv
rtl/pcmv_ram.sv
rtl/pcmv_div.sv
rtl/pcmv_datapath.sv
rtl/pcmv_ctrl.sv
rtl/per_column_running_mean_variance.sv
sim/per_column_running_mean_variance_test.sv
